/* src/tccs_pkg.sv */
// shared constants and types for the text console with cursor and scroll
package tccs_pkg;

	localparam int SCREEN_COLS_DEF = 80;
	localparam int SCREEN_ROWS_DEF = 25;

	localparam int COLOR_RESET = 7;

	// request codes
	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// character codes
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_BLANK     = 8'd32;

	// mask that rounds a tab stop down to a multiple of 8
	localparam logic [7:0] TAB_MASK = ~8'd7;

	// what a put does to the cell store
	typedef struct packed {
		logic       wr_en;
		logic [4:0] wr_row;
		logic [6:0] wr_col;
		logic [7:0] wr_char;
		logic       scroll;
	} put_info_t;

endpackage

/* src/tccs_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module tccs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* src/tccs_cursor.sv */
// cursor register and put-character decode
module tccs_cursor #(
	parameter int SCREEN_COLS = tccs_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = tccs_pkg::SCREEN_ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                put_en,
	input  logic                clear_en,
	input  logic [7:0]          char_code,
	output logic [4:0]          row,
	output logic [6:0]          col,
	output tccs_pkg::put_info_t info
);

	logic [4:0] row_q;
	logic [6:0] col_q;
	logic [7:0] col_x;
	logic [5:0] row_x;
	logic       is_bs;

	always_comb begin
		info.wr_en   = 1'b0;
		info.wr_row  = row_q;
		info.wr_col  = col_q;
		info.wr_char = char_code;
		info.scroll  = 1'b0;
		col_x        = {1'b0, col_q};
		row_x        = {1'b0, row_q};
		is_bs        = 1'b0;
		case (char_code)
			tccs_pkg::CH_NEWLINE: begin
				col_x = 8'd0;
				row_x = {1'b0, row_q} + 6'd1;
			end
			tccs_pkg::CH_RETURN: begin
				col_x = 8'd0;
			end
			tccs_pkg::CH_BACKSPACE: begin
				is_bs = 1'b1;
				if (col_q != 7'd0) begin
					col_x        = {1'b0, col_q} - 8'd1;
					info.wr_en   = 1'b1;
					info.wr_col  = col_q - 7'd1;
					info.wr_char = tccs_pkg::CH_BLANK;
				end else if (row_q != 5'd0) begin
					row_x        = {1'b0, row_q} - 6'd1;
					col_x        = 8'(SCREEN_COLS - 1);
					info.wr_en   = 1'b1;
					info.wr_row  = row_q - 5'd1;
					info.wr_col  = 7'(SCREEN_COLS - 1);
					info.wr_char = tccs_pkg::CH_BLANK;
				end
			end
			tccs_pkg::CH_TAB: begin
				col_x = ({1'b0, col_q} + 8'd8) & tccs_pkg::TAB_MASK;
			end
			default: begin
				info.wr_en = 1'b1;
				col_x      = {1'b0, col_q} + 8'd1;
			end
		endcase
		// wrap at row end, scroll past the last row (never after backspace)
		if (!is_bs && col_x >= 8'(SCREEN_COLS)) begin
			col_x = 8'd0;
			row_x = row_x + 6'd1;
		end
		if (!is_bs && row_x >= 6'(SCREEN_ROWS)) begin
			info.scroll = 1'b1;
			row_x       = 6'(SCREEN_ROWS - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 5'd0;
			col_q <= 7'd0;
		end else if (clear_en) begin
			row_q <= 5'd0;
			col_q <= 7'd0;
		end else if (put_en) begin
			row_q <= row_x[4:0];
			col_q <= col_x[6:0];
		end
	end

	assign row = row_q;
	assign col = col_q;

endmodule

/* src/text_console_cursor_scroll.sv */
// text console top level: cursor, cell store, scroll and clear sequencer, apb register
// a plain put, read or ignored request goes from idle to the finish state, then into the output register
// one request in flight: a new request is taken only in idle; a held result stalls input
// a scrolling put moves the cells up one row, drains the last moved cell, then blanks the new row
// a clear blanks every cell of the screen, one blank cell written per cycle
// reset clears the cursor and the sequencer, sets text_color to 7; the cell store has no reset
module text_console_cursor_scroll #(
	parameter int SCREEN_COLS = tccs_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = tccs_pkg::SCREEN_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [4:0]  cell_row,
	input  logic [6:0]  cell_col,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	output logic [15:0] cell_data,
	output logic        scrolled
);

	localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS;
	localparam int ADDR_W = $clog2(CELLS);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCROLL = 3'd1;
	localparam logic [2:0] ST_BLANK  = 3'd2;
	localparam logic [2:0] ST_CLEAR  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] ptr_q;
	logic              pend_s1;      // a moved cell waits for its write
	logic [ADDR_W-1:0] addr_s1;      // destination of that moved cell
	logic              res_rd_q;     // result carries the read cell
	logic              res_scroll_q;
	logic [7:0]        text_color_q;
	logic              out_valid_q;

	logic              in_fire;
	logic              put_fire;
	logic              clear_fire;
	logic              read_fire;
	logic              read_in_range;
	logic              out_free;
	logic [4:0]        cur_row;
	logic [6:0]        cur_col;
	tccs_pkg::put_info_t put_info;

	logic              ram_wr_en;
	logic [ADDR_W-1:0] ram_wr_addr;
	logic [15:0]       ram_wr_data;
	logic              ram_rd_en;
	logic [ADDR_W-1:0] ram_rd_addr;
	logic [15:0]       ram_rd_data;
	logic [15:0]       blank_cell;

	// ---------------------------------------------------------------
	// apb register: text_color at byte address 0
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {24'd0, text_color_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= 8'(tccs_pkg::COLOR_RESET);
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			text_color_q <= pwdata[7:0];
		end
	end

	assign blank_cell = {text_color_q, tccs_pkg::CH_BLANK};

	// ---------------------------------------------------------------
	// request decode
	// ---------------------------------------------------------------
	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign put_fire   = in_fire && req_type == tccs_pkg::REQ_PUT;
	assign read_fire  = in_fire && req_type == tccs_pkg::REQ_READ;
	assign clear_fire = in_fire && req_type == tccs_pkg::REQ_CLEAR;

	assign read_in_range = (32'(cell_row) < SCREEN_ROWS) && (32'(cell_col) < SCREEN_COLS);

	tccs_cursor #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_cursor (
		.clk      (clk),
		.arst_n   (arst_n),
		.put_en   (put_fire),
		.clear_en (clear_fire),
		.char_code(char_code),
		.row      (cur_row),
		.col      (cur_col),
		.info     (put_info)
	);

	// ---------------------------------------------------------------
	// cell store ports
	// ---------------------------------------------------------------
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = ptr_q;
		ram_wr_data = blank_cell;
		case (state_q)
			ST_IDLE: begin
				// character or backspace blank goes in at acceptance
				ram_wr_en   = put_fire && put_info.wr_en;
				ram_wr_addr = ADDR_W'(32'(put_info.wr_row) * SCREEN_COLS
					+ 32'(put_info.wr_col));
				ram_wr_data = {text_color_q, put_info.wr_char};
			end
			ST_SCROLL: begin
				ram_wr_en   = pend_s1;
				ram_wr_addr = addr_s1;
				ram_wr_data = ram_rd_data;
			end
			ST_BLANK: begin
				// last moved cell drains first, then the new row is blanked
				ram_wr_en = 1'b1;
				if (pend_s1) begin
					ram_wr_addr = addr_s1;
					ram_wr_data = ram_rd_data;
				end
			end
			ST_CLEAR: begin
				ram_wr_en = 1'b1;
			end
			default: begin
				ram_wr_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = ADDR_W'(32'(cell_row) * SCREEN_COLS + 32'(cell_col));
		if (state_q == ST_IDLE) begin
			ram_rd_en = read_fire;
		end else if (state_q == ST_SCROLL) begin
			// source cell is one row below the destination
			ram_rd_en   = 1'b1;
			ram_rd_addr = ptr_q + ADDR_W'(SCREEN_COLS);
		end
	end

	tccs_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_cells (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ptr_q        <= '0;
			pend_s1      <= 1'b0;
			res_rd_q     <= 1'b0;
			res_scroll_q <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_SCROLL);
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						ptr_q        <= '0;
						res_rd_q     <= read_fire && read_in_range;
						res_scroll_q <= put_fire && put_info.scroll;
						if (put_fire && put_info.scroll) begin
							state_q <= ST_SCROLL;
						end else if (clear_fire) begin
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCROLL: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == ADDR_W'(CELLS - SCREEN_COLS - 1)) begin
						state_q <= ST_BLANK;
					end
				end
				ST_BLANK: begin
					if (!pend_s1) begin
						ptr_q <= ptr_q + 1'b1;
						if (ptr_q == ADDR_W'(CELLS - 1)) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q;
	end

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			cursor_row <= cur_row;
			cursor_col <= cur_col;
			cell_data  <= res_rd_q ? ram_rd_data : 16'd0;
			scrolled   <= res_scroll_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	// a scroll always leaves the cursor on the last row
	a_scroll_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && scrolled) |-> (32'(cursor_row) == SCREEN_ROWS - 1))
		else $error("scroll result with cursor off the last row");

	// reported cursor stays inside the screen
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (32'(cursor_col) < SCREEN_COLS && 32'(cursor_row) < SCREEN_ROWS))
		else $error("cursor outside the screen");

	// during the move each write lands at a lower address than the cell being fetched
	a_move_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL && pend_s1) |-> (addr_s1 < ram_rd_addr))
		else $error("scroll write overtakes its read");

	// cell data and a scroll never come from the same request
	a_data_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && cell_data != 16'd0) |-> !scrolled)
		else $error("cell data on a scrolling put");
`endif

endmodule
